// ----- rtl/anc_pkg.sv -----
// Shared types and constants for the ancillary data packet decoder.
`default_nettype none

package anc_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic KIND_USER   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_PARITY   = 2'd2;
    localparam logic [1:0] ST_CHECKSUM = 2'd3;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  user_byte;
        logic [1:0]  status;
        logic        color_bit;
        logic [10:0] video_line;
        logic [11:0] sample_offset;
        logic        stream_flag;
        logic [6:0]  stream_number;
        logic [7:0]  data_id;
        logic [7:0]  secondary_id;
        logic [7:0]  word_count;
        logic [8:0]  consumed_bytes;
    } item_t;

    typedef struct packed {
        logic  user_vld;
        item_t user_item;
        logic  stat_vld;
        item_t stat_item;
    } push_t;

    typedef struct packed {
        logic       deliver_words;
        logic [7:0] word_capacity;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/anc_parser.sv -----
// Packet parser: header capture, 10-bit word extraction, parity, checksum, status.
`default_nettype none

module anc_parser (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  wire logic [7:0]    data_byte,
    input  wire logic          buffer_end,
    input  wire anc_pkg::cfg_t cfg,
    output anc_pkg::push_t     push
);
    import anc_pkg::*;

    logic        done_reg,     done_next;
    logic [8:0]  byte_pos_reg, byte_pos_next;
    logic [15:0] window_reg,   window_next;
    logic [3:0]  held_reg,     held_next;
    logic [8:0]  word_pos_reg, word_pos_next;
    logic [31:0] hdr_reg,      hdr_next;
    logic [7:0]  did_reg,      did_next;
    logic [7:0]  sdid_reg,     sdid_next;
    logic [7:0]  count_reg,    count_next;
    logic [8:0]  sum_reg,      sum_next;
    logic [8:0]  len_reg,      len_next;
    logic [1:0]  pend_reg,     pend_next;
    logic        stopped_reg,  stopped_next;

    function automatic logic [8:0] pkt_len(input logic [7:0] c);
        logic [12:0] bits;
        logic [9:0]  bytes;
        logic [9:0]  rnd;
        bits    = (13'(c) + 13'd4) * 13'd10 + 13'd7;
        bytes   = bits[12:3];
        rnd     = (bytes + 10'd3) & ~10'd3;
        pkt_len = 9'(rnd + 10'd4);
    endfunction

    function automatic logic parity_ok(input logic [9:0] w);
        parity_ok = (w[8] == ^w[7:0]) && (w[9] != w[8]);
    endfunction

    logic [15:0] win;
    logic [4:0]  held;
    logic        have_word;
    logic [9:0]  w;
    logic [9:0]  user_end;
    logic [1:0]  stat_code;
    logic [8:0]  sum_old;

    always_comb begin
        done_next     = done_reg;
        byte_pos_next = byte_pos_reg;
        window_next   = window_reg;
        held_next     = held_reg;
        word_pos_next = word_pos_reg;
        hdr_next      = hdr_reg;
        did_next      = did_reg;
        sdid_next     = sdid_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        len_next      = len_reg;
        pend_next     = pend_reg;
        stopped_next  = stopped_reg;

        win       = {window_reg[7:0], data_byte};
        held      = {1'b0, held_reg} + 5'd8;
        have_word = 1'b0;
        w         = '0;
        user_end  = 10'd3 + {2'b00, count_reg};
        stat_code = ST_OK;
        sum_old   = sum_reg;

        push           = '0;
        push.user_item.item_kind = KIND_USER;
        push.stat_item.item_kind = KIND_STATUS;

        if (step && !done_reg) begin
            if (byte_pos_reg < 9'd4) begin
                hdr_next = {hdr_reg[23:0], data_byte};
            end else begin
                if (held >= 5'd10) begin
                    held      = held - 5'd10;
                    have_word = 1'b1;
                    w         = 10'(win >> held[2:0]);
                end
                window_next = win;
                held_next   = held[3:0];
            end

            if (have_word) begin
                if (word_pos_reg < 9'd3) begin
                    if (!parity_ok(w) && pend_reg == ST_OK) begin
                        pend_next = ST_PARITY;
                    end
                    sum_next = sum_reg + w[8:0];
                    case (word_pos_reg[1:0])
                        2'd0:    did_next  = w[7:0];
                        2'd1:    sdid_next = w[7:0];
                        default: begin
                            count_next = w[7:0];
                            len_next   = pkt_len(w[7:0]);
                        end
                    endcase
                end else if ({1'b0, word_pos_reg} < user_end) begin
                    sum_next = sum_reg + w[8:0];
                    if (!parity_ok(w)) begin
                        stopped_next = 1'b1;
                        if (pend_reg == ST_OK) begin
                            pend_next = ST_PARITY;
                        end
                    end else if (cfg.deliver_words && !stopped_reg) begin
                        push.user_vld            = 1'b1;
                        push.user_item.user_byte = w[7:0];
                    end
                end else if ({1'b0, word_pos_reg} == user_end) begin
                    if (w != {~sum_old[8], sum_old} && pend_reg == ST_OK) begin
                        pend_next = ST_CHECKSUM;
                    end
                end
                if (word_pos_reg != 9'h1FF) begin
                    word_pos_next = word_pos_reg + 9'd1;
                end
            end

            if (byte_pos_reg == 9'd7) begin
                if (pend_next != ST_OK) begin
                    push.stat_vld = 1'b1;
                    stat_code     = ST_PARITY;
                end else if (cfg.deliver_words && count_next > cfg.word_capacity) begin
                    push.stat_vld = 1'b1;
                    stat_code     = ST_SHORT;
                end
            end else if (byte_pos_reg > 9'd7
                         && {1'b0, byte_pos_reg} + 10'd1 == {1'b0, len_next}) begin
                push.stat_vld = 1'b1;
                stat_code     = pend_next;
            end

            if (!push.stat_vld && buffer_end) begin
                push.stat_vld = 1'b1;
                stat_code     = ST_SHORT;
            end

            if (push.stat_vld) begin
                done_next = 1'b1;
            end
            if (byte_pos_reg != 9'h1FF) begin
                byte_pos_next = byte_pos_reg + 9'd1;
            end
        end

        push.stat_item.status = stat_code;
        if (stat_code == ST_OK) begin
            push.stat_item.color_bit      = hdr_next[31];
            push.stat_item.video_line     = hdr_next[30:20];
            push.stat_item.sample_offset  = hdr_next[19:8];
            push.stat_item.stream_flag    = hdr_next[7];
            push.stat_item.stream_number  = hdr_next[6:0];
            push.stat_item.data_id        = did_next;
            push.stat_item.secondary_id   = sdid_next;
            push.stat_item.word_count     = count_next;
            push.stat_item.consumed_bytes = len_next;
        end

        if (step && buffer_end) begin
            done_next     = 1'b0;
            byte_pos_next = '0;
            window_next   = '0;
            held_next     = '0;
            word_pos_next = '0;
            hdr_next      = '0;
            did_next      = '0;
            sdid_next     = '0;
            count_next    = '0;
            sum_next      = '0;
            len_next      = '0;
            pend_next     = ST_OK;
            stopped_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg     <= 1'b0;
            byte_pos_reg <= '0;
            window_reg   <= '0;
            held_reg     <= '0;
            word_pos_reg <= '0;
            hdr_reg      <= '0;
            did_reg      <= '0;
            sdid_reg     <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            len_reg      <= '0;
            pend_reg     <= ST_OK;
            stopped_reg  <= 1'b0;
        end else begin
            done_reg     <= done_next;
            byte_pos_reg <= byte_pos_next;
            window_reg   <= window_next;
            held_reg     <= held_next;
            word_pos_reg <= word_pos_next;
            hdr_reg      <= hdr_next;
            did_reg      <= did_next;
            sdid_reg     <= sdid_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            len_reg      <= len_next;
            pend_reg     <= pend_next;
            stopped_reg  <= stopped_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/anc_out_fifo.sv -----
// Result queue: takes up to two words per cycle, hands out one per cycle while m_rdy is high.
`default_nettype none

module anc_out_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire anc_pkg::push_t push,
    output logic                room,
    output logic                m_vld,
    input  wire logic           m_rdy,
    output anc_pkg::item_t      m_item
);
    import anc_pkg::*;

    item_t            mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;
    logic [PTR_W-1:0] stat_ptr;

    assign m_vld    = (count_reg != '0);
    assign m_item   = mem[rd_ptr_reg];
    assign pop      = m_vld && m_rdy;
    assign room     = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign stat_ptr = push.user_vld ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.user_vld) + PTR_W'(push.stat_vld);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.user_vld) + CNT_W'(push.stat_vld)
                      - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.user_vld) begin
            mem[wr_ptr_reg] <= push.user_item;
        end
        if (push.stat_vld) begin
            mem[stat_ptr] <= push.stat_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/anc_packet_decoder.sv -----
// Top level: input register, APB registers, parser and result queue.
// Flow: a byte waits in the input register until the queue has room; its words are then queued.
// Throughput: one byte per cycle with room; a byte's two words leave one per cycle on m_ready.
// The four-word result queue stalls s_ready once fewer than two slots are free.
// Reset: synchronous, active low; clears packet state and the queue, deliver_words=1,
// word_capacity=255.
`default_nettype none

module anc_packet_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_buffer_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_item_kind,
    output logic [7:0]       m_user_byte,
    output logic [1:0]       m_status,
    output logic             m_color_bit,
    output logic [10:0]      m_video_line,
    output logic [11:0]      m_sample_offset,
    output logic             m_stream_flag,
    output logic [6:0]       m_stream_number,
    output logic [7:0]       m_data_id,
    output logic [7:0]       m_secondary_id,
    output logic [7:0]       m_word_count,
    output logic [8:0]       m_consumed_bytes,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import anc_pkg::*;

    localparam logic REG_DELIVER  = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       deliver_reg;
    logic [7:0] capacity_reg;
    logic       room;
    logic       step;
    logic       wr_en;
    cfg_t       cfg;
    push_t      push;
    item_t      m_item;

    assign step    = in_vld_reg && room;
    assign s_ready = !in_vld_reg || room;
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    assign cfg.deliver_words = deliver_reg;
    assign cfg.word_capacity = capacity_reg;

    always_comb begin
        unique case (paddr[2])
            REG_DELIVER:  prdata = {31'd0, deliver_reg};
            REG_CAPACITY: prdata = {24'd0, capacity_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deliver_reg  <= 1'b1;
            capacity_reg <= 8'hFF;
        end else if (wr_en) begin
            if (paddr[2] == REG_DELIVER) begin
                deliver_reg <= pwdata[0];
            end else begin
                capacity_reg <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (step) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_buffer_end;
        end
    end

    anc_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .data_byte  (in_byte_reg),
        .buffer_end (in_last_reg),
        .cfg        (cfg),
        .push       (push)
    );

    anc_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_vld   (m_valid),
        .m_rdy   (m_ready),
        .m_item  (m_item)
    );

    assign m_item_kind      = m_item.item_kind;
    assign m_user_byte      = m_item.user_byte;
    assign m_status         = m_item.status;
    assign m_color_bit      = m_item.color_bit;
    assign m_video_line     = m_item.video_line;
    assign m_sample_offset  = m_item.sample_offset;
    assign m_stream_flag    = m_item.stream_flag;
    assign m_stream_number  = m_item.stream_number;
    assign m_data_id        = m_item.data_id;
    assign m_secondary_id   = m_item.secondary_id;
    assign m_word_count     = m_item.word_count;
    assign m_consumed_bytes = m_item.consumed_bytes;

    a_user_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item_kind == KIND_USER |->
            m_status == ST_OK && m_consumed_bytes == '0 && m_word_count == '0)
        else $error("user data word carries status fields");

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item_kind == KIND_STATUS && m_status != ST_OK |->
            m_consumed_bytes == '0 && m_data_id == '0 && m_user_byte == '0)
        else $error("error status carries metadata");

    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item_kind == KIND_STATUS && m_status == ST_OK |->
            m_consumed_bytes[1:0] == 2'b00 && m_consumed_bytes >= 9'd12)
        else $error("ok status with malformed packet length");

    a_no_step_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !room |=> in_vld_reg && $stable(in_byte_reg))
        else $error("held input byte lost while queue full");

endmodule

`default_nettype wire

// ----- test/tb_anc_packet_decoder.sv -----
// Testbench for the ancillary data packet decoder: directed table, random buffers, predictor.
`timescale 1ns / 100ps

module tb_anc_packet_decoder;
    import anc_pkg::*;

    localparam logic [2:0] REG_DELIVER  = 3'd0;
    localparam logic [2:0] REG_CAPACITY = 3'd4;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 80;
    localparam int PHASE_BYTES   = 65;

    typedef enum int {
        BUF_CLEAN, BUF_USER_PARITY, BUF_HDR_PARITY, BUF_CHECKSUM, BUF_CUT, BUF_TRAILING, BUF_NOISE
    } buf_shape_e;

    typedef struct packed {
        logic  has_want;
        item_t want;
    } tag_t;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
        tag_t       tag;
    } row_t;

    localparam tag_t NO_TAG = '0;
    localparam item_t WANT_SHORT  = '{item_kind: KIND_STATUS, status: ST_SHORT, default: '0};
    localparam item_t WANT_PARITY = '{item_kind: KIND_STATUS, status: ST_PARITY, default: '0};
    localparam item_t WANT_OK = '{
        item_kind: KIND_STATUS, user_byte: 8'h00, status: ST_OK, color_bit: 1'b1,
        video_line: 11'h7FF, sample_offset: 12'hFFF, stream_flag: 1'b1,
        stream_number: 7'h7F, data_id: 8'h61, secondary_id: 8'h01, word_count: 8'h00,
        consumed_bytes: 9'd12
    };

    // lone end byte; all-ones header with DID 0x61, SDID 0x01, no user words;
    // all-zero buffer whose DID word has broken parity
    localparam row_t DIRECTED [21] = '{
        '{8'h00, 1'b1, '{1'b1, WANT_SHORT}},
        '{8'hFF, 1'b0, NO_TAG}, '{8'hFF, 1'b0, NO_TAG},
        '{8'hFF, 1'b0, NO_TAG}, '{8'hFF, 1'b0, NO_TAG},
        '{8'h58, 1'b0, NO_TAG}, '{8'h50, 1'b0, NO_TAG},
        '{8'h18, 1'b0, NO_TAG}, '{8'h02, 1'b0, NO_TAG},
        '{8'h62, 1'b0, NO_TAG}, '{8'h00, 1'b0, NO_TAG},
        '{8'h00, 1'b0, NO_TAG}, '{8'h00, 1'b1, '{1'b1, WANT_OK}},
        '{8'h00, 1'b0, NO_TAG}, '{8'h00, 1'b0, NO_TAG},
        '{8'h00, 1'b0, NO_TAG}, '{8'h00, 1'b0, NO_TAG},
        '{8'h00, 1'b0, NO_TAG}, '{8'h00, 1'b0, NO_TAG},
        '{8'h00, 1'b0, NO_TAG}, '{8'h00, 1'b1, '{1'b1, WANT_PARITY}}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_buffer_end;
    logic        m_valid;
    logic        m_ready;
    logic        m_item_kind;
    logic [7:0]  m_user_byte;
    logic [1:0]  m_status;
    logic        m_color_bit;
    logic [10:0] m_video_line;
    logic [11:0] m_sample_offset;
    logic        m_stream_flag;
    logic [6:0]  m_stream_number;
    logic [7:0]  m_data_id;
    logic [7:0]  m_secondary_id;
    logic [7:0]  m_word_count;
    logic [8:0]  m_consumed_bytes;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    anc_packet_decoder uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_buffer_end(s_buffer_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_item_kind(m_item_kind), .m_user_byte(m_user_byte), .m_status(m_status),
        .m_color_bit(m_color_bit), .m_video_line(m_video_line),
        .m_sample_offset(m_sample_offset), .m_stream_flag(m_stream_flag),
        .m_stream_number(m_stream_number), .m_data_id(m_data_id),
        .m_secondary_id(m_secondary_id), .m_word_count(m_word_count),
        .m_consumed_bytes(m_consumed_bytes),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // decoder shadow: registers and packet state
    logic        cfg_deliver;
    logic [7:0]  cfg_cap;
    logic [8:0]  at_byte;
    logic [15:0] bitbuf;
    logic [3:0]  bitcnt;
    logic [8:0]  at_word;
    logic [47:0] hdr_bits;
    logic [8:0]  run_sum;
    logic [8:0]  pkt_len;
    logic [1:0]  held_err;
    logic        user_off;
    logic [7:0]  cnt_seen;
    logic        answered;

    item_t fresh_q[$];
    item_t expected_words[$];
    tag_t  tag_q[$];

    int errors = 0;
    int words_checked = 0;
    int bytes_sent = 0;
    int burst_left = 0;
    int hold_asks = 0;
    int settings_used = 0;
    int shape_count[7];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (errors < 40) begin
            $display("ERROR %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want, $time);
        end
        errors++;
    endtask

    function automatic logic good_parity(input logic [9:0] w);
        return w == {~(^w[7:0]), ^w[7:0], w[7:0]};
    endfunction

    function automatic logic [9:0] with_parity(input logic [7:0] v);
        return {~(^v), ^v, v};
    endfunction

    function automatic void clear_packet();
        at_byte  = '0;
        bitbuf   = '0;
        bitcnt   = '0;
        at_word  = '0;
        hdr_bits = '0;
        run_sum  = '0;
        pkt_len  = '0;
        held_err = ST_OK;
        user_off = 1'b0;
        cnt_seen = '0;
        answered = 1'b0;
    endfunction

    function automatic void post_status(input logic [1:0] st);
        item_t it;
        it = '0;
        it.item_kind = KIND_STATUS;
        it.status = st;
        if (st == ST_OK) begin
            it.color_bit      = hdr_bits[31];
            it.video_line     = hdr_bits[30:20];
            it.sample_offset  = hdr_bits[19:8];
            it.stream_flag    = hdr_bits[7];
            it.stream_number  = hdr_bits[6:0];
            it.data_id        = hdr_bits[39:32];
            it.secondary_id   = hdr_bits[47:40];
            it.word_count     = cnt_seen;
            it.consumed_bytes = pkt_len;
        end
        fresh_q.push_back(it);
        answered = 1'b1;
    endfunction

    function automatic void take_word(input logic [9:0] w);
        item_t it;
        int nb;
        if (at_word < 3) begin
            if (!good_parity(w) && held_err == ST_OK) held_err = ST_PARITY;
            run_sum = 9'(run_sum + w);
            if (at_word == 0) begin
                hdr_bits[39:32] = w[7:0];
            end else if (at_word == 1) begin
                hdr_bits[47:40] = w[7:0];
            end else begin
                cnt_seen = w[7:0];
                nb = ((4 + int'(cnt_seen)) * 10 + 7) / 8;
                pkt_len = 9'(4 + ((nb + 3) / 4) * 4);
            end
        end else if (at_word < 3 + cnt_seen) begin
            run_sum = 9'(run_sum + w);
            if (!good_parity(w)) begin
                user_off = 1'b1;
                if (held_err == ST_OK) held_err = ST_PARITY;
            end else if (cfg_deliver && !user_off) begin
                it = '0;
                it.item_kind = KIND_USER;
                it.user_byte = w[7:0];
                fresh_q.push_back(it);
            end
        end else if (at_word == 3 + cnt_seen) begin
            if (w != {~run_sum[8], run_sum} && held_err == ST_OK) held_err = ST_CHECKSUM;
        end
        if (at_word != 9'd511) at_word++;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic last);
        logic [15:0] nwin;
        int nheld;
        if (!answered) begin
            if (at_byte < 4) begin
                hdr_bits[31:0] = {hdr_bits[23:0], b};
            end else begin
                nwin = {bitbuf[7:0], b};
                nheld = bitcnt + 8;
                while (nheld >= 10) begin
                    nheld -= 10;
                    take_word(10'(nwin >> nheld));
                end
                bitbuf = nwin;
                bitcnt = 4'(nheld);
            end
            if (at_byte == 7) begin
                if (held_err != ST_OK) post_status(ST_PARITY);
                else if (cfg_deliver && cnt_seen > cfg_cap) post_status(ST_SHORT);
            end else if (at_byte > 7 && at_byte + 1 == pkt_len) begin
                post_status(held_err);
            end
            if (!answered && last) post_status(ST_SHORT);
            if (at_byte != 9'd511) at_byte++;
        end
        if (last) clear_packet();
    endfunction

    task automatic check_word(input item_t got);
        item_t want;
        words_checked++;
        if (expected_words.size() == 0) begin
            report("word with none expected, kind", got.item_kind, 0);
            return;
        end
        want = expected_words.pop_front();
        if (got.item_kind != want.item_kind)
            report("item_kind", got.item_kind, want.item_kind);
        if (got.user_byte != want.user_byte)
            report("user_byte", got.user_byte, want.user_byte);
        if (got.status != want.status)
            report("status", got.status, want.status);
        if (got.color_bit != want.color_bit)
            report("color_bit", got.color_bit, want.color_bit);
        if (got.video_line != want.video_line)
            report("video_line", got.video_line, want.video_line);
        if (got.sample_offset != want.sample_offset)
            report("sample_offset", got.sample_offset, want.sample_offset);
        if (got.stream_flag != want.stream_flag)
            report("stream_flag", got.stream_flag, want.stream_flag);
        if (got.stream_number != want.stream_number)
            report("stream_number", got.stream_number, want.stream_number);
        if (got.data_id != want.data_id)
            report("data_id", got.data_id, want.data_id);
        if (got.secondary_id != want.secondary_id)
            report("secondary_id", got.secondary_id, want.secondary_id);
        if (got.word_count != want.word_count)
            report("word_count", got.word_count, want.word_count);
        if (got.consumed_bytes != want.consumed_bytes)
            report("consumed_bytes", got.consumed_bytes, want.consumed_bytes);
    endtask

    always @(posedge aclk) begin
        tag_t tag;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                check_word('{m_item_kind, m_user_byte, m_status, m_color_bit, m_video_line,
                    m_sample_offset, m_stream_flag, m_stream_number, m_data_id,
                    m_secondary_id, m_word_count, m_consumed_bytes});
            end
            if (s_valid && s_ready) begin
                tag = tag_q.pop_front();
                fresh_q.delete();
                predict_byte(s_data_byte, s_buffer_end);
                if (tag.has_want) begin
                    expected_words.push_back(tag.want);
                end else begin
                    foreach (fresh_q[i]) expected_words.push_back(fresh_q[i]);
                end
            end
        end
    end

    // receiver: stall pattern changes every so often; long hold-off on request
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        int holds_seen;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        holds_seen = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asks != holds_seen) begin
                holds_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 9) < 3);
                    default: m_ready <= mode_left[1];
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic e, input tag_t tag);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 16);
        end
        burst_left--;
        tag_q.push_back(tag);
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_buffer_end <= e;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic dw, input logic [7:0] cap);
        logic [31:0] rd;
        apb_access(1'b1, REG_DELIVER, {31'd0, dw}, rd);
        apb_access(1'b1, REG_CAPACITY, {24'd0, cap}, rd);
        cfg_deliver = dw;
        cfg_cap = cap;
        apb_access(1'b0, REG_DELIVER, '0, rd);
        if (rd != {31'd0, dw}) report("deliver_words readback", rd, {31'd0, dw});
        apb_access(1'b0, REG_CAPACITY, '0, rd);
        if (rd != {24'd0, cap}) report("word_capacity readback", rd, {24'd0, cap});
        settings_used++;
    endtask

    // one buffer: mostly well-formed packets, some damaged, cut, padded out or pure noise
    task automatic send_buffer();
        logic [9:0]  words[$];
        logic [7:0]  bytes_q[$];
        logic [8:0]  sum;
        logic [31:0] acc;
        buf_shape_e  shape;
        int r, nbits, cnt, total, k;
        r = $urandom_range(0, 99);
        if (r < 55) shape = BUF_CLEAN;
        else if (r < 65) shape = BUF_USER_PARITY;
        else if (r < 73) shape = BUF_HDR_PARITY;
        else if (r < 81) shape = BUF_CHECKSUM;
        else if (r < 89) shape = BUF_CUT;
        else if (r < 95) shape = BUF_TRAILING;
        else shape = BUF_NOISE;
        shape_count[shape]++;

        if (shape == BUF_NOISE) begin
            total = $urandom_range(1, 24);
            for (int i = 0; i < total; i++) send_byte(8'($urandom), i == total - 1, NO_TAG);
            return;
        end

        r = $urandom_range(0, 99);
        if (r < 70) cnt = $urandom_range(0, 12);
        else if (r < 96) cnt = $urandom_range(13, 60);
        else if (r < 99) cnt = $urandom_range(200, 254);
        else cnt = 255;

        words.push_back(with_parity(8'($urandom)));
        words.push_back(with_parity(8'($urandom)));
        words.push_back(with_parity(8'(cnt)));
        for (int i = 0; i < cnt; i++) words.push_back(with_parity(8'($urandom)));
        if (shape == BUF_HDR_PARITY) begin
            k = $urandom_range(0, 2);
            words[k] = words[k] ^ (10'd1 << $urandom_range(8, 9));
        end
        if (shape == BUF_USER_PARITY && cnt > 0) begin
            k = 3 + $urandom_range(0, cnt - 1);
            words[k] = words[k] ^ (10'd1 << $urandom_range(0, 9));
        end
        sum = '0;
        foreach (words[i]) sum = 9'(sum + words[i]);
        words.push_back({~sum[8], sum});
        if (shape == BUF_CHECKSUM) begin
            k = words.size() - 1;
            words[k] = words[k] ^ (10'd1 << $urandom_range(0, 9));
        end

        for (int i = 0; i < 4; i++) bytes_q.push_back(8'($urandom));
        acc = '0;
        nbits = 0;
        foreach (words[i]) begin
            acc = {acc[21:0], words[i]};
            nbits += 10;
            while (nbits >= 8) begin
                nbits -= 8;
                bytes_q.push_back(8'(acc >> nbits));
            end
        end
        if (nbits > 0)
            bytes_q.push_back(8'((acc << (8 - nbits)) | ($urandom & ((1 << (8 - nbits)) - 1))));
        while (bytes_q.size() % 4 != 0) bytes_q.push_back(8'($urandom));

        total = bytes_q.size();
        if (shape == BUF_CUT) total = $urandom_range(1, bytes_q.size() - 1);
        if (shape == BUF_TRAILING) total += $urandom_range(1, 6);
        for (int i = 0; i < total; i++) begin
            send_byte(i < bytes_q.size() ? bytes_q[i] : 8'($urandom), i == total - 1, NO_TAG);
        end
    endtask

    initial begin
        int phase_start;
        int nbuf;
        s_valid <= 1'b0;
        s_data_byte <= '0;
        s_buffer_end <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        aresetn <= 1'b0;
        cfg_deliver = 1'b1;
        cfg_cap = 8'd255;
        clear_packet();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) send_byte(DIRECTED[i].b, DIRECTED[i].e, DIRECTED[i].tag);

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: set_config(1'b1, 8'd255);
                1: set_config(1'b0, 8'd0);
                2: set_config(1'b1, 8'd0);
                3: set_config(1'b1, 8'($urandom_range(1, 20)));
                4: set_config(1'b0, 8'd255);
                default: set_config(1'b1, 8'($urandom_range(8, 40)));
            endcase
            phase_start = bytes_sent;
            nbuf = 0;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if (ph == 0 && nbuf == 0) hold_asks <= hold_asks + 1;
                if (ph == 2 && nbuf == 1) wait_idle();
                send_buffer();
                nbuf++;
            end
        end
        wait_idle();

        $display("Sent %0d bytes under %0d register settings; %0d result words compared",
                 bytes_sent, settings_used, words_checked);
        $display("Buffers: %0d clean, %0d user parity, %0d header parity, %0d checksum,",
                 shape_count[BUF_CLEAN], shape_count[BUF_USER_PARITY],
                 shape_count[BUF_HDR_PARITY], shape_count[BUF_CHECKSUM]);
        $display("         %0d cut, %0d trailing, %0d noise",
                 shape_count[BUF_CUT], shape_count[BUF_TRAILING], shape_count[BUF_NOISE]);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
